// ----- hw/rtl/scr_pkg.sv -----
// ---------------------------------------------------------------------------
// scr_pkg
// Shared types and constants of the sphere collision response block.
// ---------------------------------------------------------------------------
`default_nettype none

package scr_pkg;

    typedef enum logic [1:0] {
        MODE_SPHERE = 2'd0,
        MODE_MESH   = 2'd1,
        MODE_NONE   = 2'd2
    } t_mode;

    // fraction bits of the unit vectors for a given value width
    function automatic int scr_unit_bits(input int w);
        return ((62 - w) < 30) ? (62 - w) : 30;
    endfunction

    // register stages of one unit vector pipe
    function automatic int scr_unit_latency(input int w);
        return 39 + scr_unit_bits(w);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scr_delay.sv -----
// ---------------------------------------------------------------------------
// scr_delay
// Enabled shift line that carries side data along a pipeline section.
// ---------------------------------------------------------------------------
`default_nettype none

module scr_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

`default_nettype wire

// ----- hw/rtl/scr_unit.sv -----
// ---------------------------------------------------------------------------
// scr_unit
// Pipelined unit vector: range scaling, squared length, bit-per-stage square
// root and bit-per-stage division of each component by the length.
// ---------------------------------------------------------------------------
`default_nettype none

module scr_unit #(
    parameter int W = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic signed [W-1:0]                    i_d [3],
    output logic signed [scr_pkg::scr_unit_bits(W)+1:0] o_u [3]
);
    import scr_pkg::*;

    localparam int UB  = scr_unit_bits(W);
    localparam int QB  = UB + 1;
    localparam int UW  = UB + 2;
    localparam int SHW = $clog2(W);

    typedef struct packed {
        logic [33:0]      rem;
        logic [30:0]      root;
        logic [61:0]      rad;
        logic [2:0][29:0] e;
        logic [2:0]       neg;
        logic             nz;
    } t_sqs;

    typedef struct packed {
        logic [30:0]          len;
        logic [2:0][30:0]     rem;
        logic [2:0][QB-1:0]   bits;
        logic [2:0][QB-1:0]   quo;
        logic [2:0]           neg;
        logic                 nz;
    } t_dvs;

    logic [W-1:0]  r_mag0 [3];
    logic [2:0]    r_neg0;
    logic [W-1:0]  r_mag1 [3];
    logic [2:0]    r_neg1;
    logic [SHW-1:0] r_sh1;
    logic          r_nz1;
    logic [29:0]   r_e2 [3];
    logic [2:0]    r_neg2;
    logic          r_nz2;
    logic [59:0]   r_sq3 [3];
    logic [29:0]   r_e3 [3];
    logic [2:0]    r_neg3;
    logic          r_nz3;
    t_sqs          r_sqs [32];
    t_sqs          n_sqs [32];
    t_dvs          r_dvs [QB+1];
    t_dvs          n_dvs [QB+1];
    logic signed [UW-1:0] r_u [3];

    logic [W-1:0]   w_max;
    logic [SHW-1:0] w_sh;

    always_comb begin
        w_max = r_mag0[0];
        if (r_mag0[1] > w_max) w_max = r_mag0[1];
        if (r_mag0[2] > w_max) w_max = r_mag0[2];
        w_sh = '0;
        // bring the largest magnitude below 2^30
        for (int k = 30; k < W; k++) begin
            if (w_max[k]) w_sh = SHW'(k - 29);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_neg0[i] <= i_d[i][W-1];
                r_mag0[i] <= i_d[i][W-1] ? (~i_d[i] + 1'b1) : i_d[i];
                r_mag1[i] <= r_mag0[i];
                r_e2[i]   <= 30'(r_mag1[i] >> r_sh1);
                r_sq3[i]  <= 60'(r_e2[i]) * 60'(r_e2[i]);
                r_e3[i]   <= r_e2[i];
            end
            r_neg1 <= r_neg0;
            r_sh1  <= w_sh;
            r_nz1  <= (w_max != '0);
            r_neg2 <= r_neg1;
            r_nz2  <= r_nz1;
            r_neg3 <= r_neg2;
            r_nz3  <= r_nz2;
            r_sqs[0].rem  <= '0;
            r_sqs[0].root <= '0;
            r_sqs[0].rad  <= 62'(r_sq3[0]) + 62'(r_sq3[1]) + 62'(r_sq3[2]);
            r_sqs[0].e    <= {r_e3[2], r_e3[1], r_e3[0]};
            r_sqs[0].neg  <= r_neg3;
            r_sqs[0].nz   <= r_nz3;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < 31; k++) begin : g_sqrt
        logic [33:0] w_rem;
        logic [33:0] w_trial;
        assign w_rem   = {r_sqs[k].rem[31:0], r_sqs[k].rad[61:60]};
        assign w_trial = {1'b0, r_sqs[k].root, 2'b01};
        always_comb begin
            n_sqs[k+1]     = r_sqs[k];
            n_sqs[k+1].rad = {r_sqs[k].rad[59:0], 2'b00};
            if (w_rem >= w_trial) begin
                n_sqs[k+1].rem  = w_rem - w_trial;
                n_sqs[k+1].root = {r_sqs[k].root[29:0], 1'b1};
            end else begin
                n_sqs[k+1].rem  = w_rem;
                n_sqs[k+1].root = {r_sqs[k].root[29:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sqs[k+1] <= n_sqs[k+1];
            end
        end
    end

    assign n_sqs[0] = r_sqs[0];

    always_comb begin
        n_dvs[0].len = (r_sqs[31].root == '0) ? 31'd1 : r_sqs[31].root;
        for (int i = 0; i < 3; i++) begin
            n_dvs[0].rem[i]  = 31'(r_sqs[31].e[i] >> 1);
            n_dvs[0].bits[i] = {r_sqs[31].e[i][0], {UB{1'b0}}};
            n_dvs[0].quo[i]  = '0;
        end
        n_dvs[0].neg = r_sqs[31].neg;
        n_dvs[0].nz  = r_sqs[31].nz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvs[0] <= n_dvs[0];
        end
    end

    // long division of each component by the length, one quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
        always_comb begin
            logic [31:0] t;
            n_dvs[j+1] = r_dvs[j];
            for (int i = 0; i < 3; i++) begin
                t = {r_dvs[j].rem[i], r_dvs[j].bits[i][QB-1]};
                n_dvs[j+1].bits[i] = {r_dvs[j].bits[i][QB-2:0], 1'b0};
                if (t >= {1'b0, r_dvs[j].len}) begin
                    n_dvs[j+1].rem[i] = 31'(t - {1'b0, r_dvs[j].len});
                    n_dvs[j+1].quo[i] = {r_dvs[j].quo[i][QB-2:0], 1'b1};
                end else begin
                    n_dvs[j+1].rem[i] = t[30:0];
                    n_dvs[j+1].quo[i] = {r_dvs[j].quo[i][QB-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvs[j+1] <= n_dvs[j+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (!r_dvs[QB].nz) begin
                    r_u[i] <= '0;
                end else if (r_dvs[QB].neg[i]) begin
                    r_u[i] <= -signed'(UW'(r_dvs[QB].quo[i]));
                end else begin
                    r_u[i] <= signed'(UW'(r_dvs[QB].quo[i]));
                end
            end
        end
    end

    assign o_u = r_u;

endmodule

`default_nettype wire

// ----- hw/rtl/sphere_collision_response.sv -----
// ---------------------------------------------------------------------------
// sphere_collision_response
// Velocity exchange and position correction, one collision pair per cycle unless stalled.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tdata holds offset x/y/z, velocity A x/y/z,
//   velocity B x/y/z and penetration depth; tuser holds the mode.
//   Output stream m_axis: tdata holds new velocity A, new velocity B and the
//   position shift of A, each x/y/z.
//   One pair is accepted per clock while the output is not held. The two
//   unit vector pipes, with UB = min(62-VALUE_WIDTH, 30), are each a
//   31-stage square root followed by a UB+1 stage divider.
//   The pipeline advances as one: when the output word is held by the
//   receiver, every stage holds and s_axis tready drops, so nothing is lost
//   or repeated. A bubble-free stream runs at one word per cycle while
//   the receiver keeps tready high.
//   Reset clears the valid bits of all stages; data registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module sphere_collision_response #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_s_axis_tvalid,
    output logic                                               o_s_axis_tready,
    // offset_x, offset_y, offset_z, velocity_a_x/y/z, velocity_b_x/y/z,
    // penetration_depth, zero fill
    input  wire logic [((10*VALUE_WIDTH-1+7)/8)*8-1:0]         i_s_axis_tdata,
    // mode
    input  wire logic [1:0]                                    i_s_axis_tuser,
    output logic                                               o_m_axis_tvalid,
    input  wire logic                                          i_m_axis_tready,
    // new_velocity_a_x/y/z, new_velocity_b_x/y/z, shift_a_x/y/z, zero fill
    output logic [((9*VALUE_WIDTH+7)/8)*8-1:0]                 o_m_axis_tdata
);
    import scr_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int UB     = scr_unit_bits(W);
    localparam int UW     = UB + 2;
    localparam int LU     = scr_unit_latency(W);
    localparam int NV     = 2 * LU + 8;
    localparam int PW     = W + UW;
    localparam int XW     = W + UB + 4;
    localparam int SW     = W + 2;
    localparam int SSW    = SW + 2;
    localparam int OUT_TW = ((9 * W + 7) / 8) * 8;
    localparam int SB1    = 2 + 6 * W + (W - 1);
    localparam int SB2    = 2 + 6 * W + (W - 1);

    localparam logic signed [SSW-1:0] MAXV = SSW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [SSW-1:0] MINV = -MAXV - SSW'(1);

    function automatic logic signed [W-1:0] f_sat(input logic signed [SSW-1:0] x);
        logic signed [SSW-1:0] y;
        y = x;
        if (x > MAXV) y = MAXV;
        if (x < MINV) y = MINV;
        return y[W-1:0];
    endfunction

    // arithmetic right shift by UB, rounding toward zero
    function automatic logic signed [XW-1:0] f_shr_tz(input logic signed [XW-1:0] x);
        logic [XW-1:0] m;
        m = x[XW-1] ? (~x + 1'b1) : x;
        m = m >> UB;
        return x[XW-1] ? signed'(~m + 1'b1) : signed'(m);
    endfunction

    logic w_en;
    logic [NV-1:0] r_vld;

    assign w_en            = !r_vld[NV-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_s_axis_tvalid};
        end
    end

    // input unpacking
    logic signed [W-1:0] w_off [3];
    logic [W-2:0]        w_depth;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_off[i] = signed'(i_s_axis_tdata[i*W +: W]);
        end
    end
    assign w_depth = i_s_axis_tdata[9*W +: W-1];

    // first unit vector: along the centre line
    logic signed [UW-1:0] w_u1 [3];

    scr_unit #(.W(W)) u_unit_off (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_off),
        .o_u   (w_u1)
    );

    logic [SB1-1:0] w_sb1;

    scr_delay #(.WIDTH(SB1), .DEPTH(LU)) u_dly_in (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_depth, i_s_axis_tdata[6*W +: 3*W], i_s_axis_tdata[3*W +: 3*W],
                 i_s_axis_tuser}),
        .o_q   (w_sb1)
    );

    logic signed [W-1:0] w_va [3];
    logic signed [W-1:0] w_vb [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_va[i] = signed'(w_sb1[2 + i*W +: W]);
            w_vb[i] = signed'(w_sb1[2 + 3*W + i*W +: W]);
        end
    end

    // projection and exchange stages
    t_mode               r_p1_mode, r_p2_mode, r_p3_mode, r_p4_mode, r_p5_mode, r_p6_mode;
    logic [W-2:0]        r_p1_dep, r_p2_dep, r_p3_dep, r_p4_dep, r_p5_dep, r_p6_dep;
    logic signed [W-1:0] r_p1_va [3];
    logic signed [W-1:0] r_p1_vb [3];
    logic signed [W-1:0] r_p2_va [3];
    logic signed [W-1:0] r_p2_vb [3];
    logic signed [W-1:0] r_p3_va [3];
    logic signed [W-1:0] r_p3_vb [3];
    logic signed [W-1:0] r_p4_va [3];
    logic signed [W-1:0] r_p4_vb [3];
    logic signed [W-1:0] r_p5_va [3];
    logic signed [W-1:0] r_p5_vb [3];
    logic signed [UW-1:0] r_p1_u [3];
    logic signed [UW-1:0] r_p2_u [3];
    logic signed [UW-1:0] r_p3_u [3];
    logic signed [PW-1:0] r_pam [3];
    logic signed [PW-1:0] r_pbm [3];
    logic signed [XW-1:0] r_dot_a, r_dot_b;
    logic signed [SW-1:0] r_s_a, r_s_b;
    logic signed [XW-1:0] r_qa [3];
    logic signed [XW-1:0] r_qb [3];
    logic signed [SW-1:0] r_pa [3];
    logic signed [SW-1:0] r_pb [3];
    logic signed [W-1:0]  r_na [3];
    logic signed [W-1:0]  r_nb [3];
    logic signed [W-1:0]  n_na [3];
    logic signed [W-1:0]  n_nb [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r_p5_mode)
                MODE_SPHERE: begin
                    n_na[i] = f_sat(SSW'(r_p5_va[i]) + SSW'(r_pb[i]) - SSW'(r_pa[i]));
                    n_nb[i] = f_sat(SSW'(r_p5_vb[i]) + SSW'(r_pa[i]) - SSW'(r_pb[i]));
                end
                MODE_MESH: begin
                    n_na[i] = f_sat(SSW'(0) - SSW'(r_p5_va[i]));
                    n_nb[i] = f_sat(SSW'(0) - SSW'(r_p5_vb[i]));
                end
                default: begin
                    n_na[i] = r_p5_va[i];
                    n_nb[i] = r_p5_vb[i];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_mode <= t_mode'(w_sb1[1:0]);
            r_p1_dep  <= w_sb1[2 + 6*W +: W-1];
            r_p2_mode <= r_p1_mode;
            r_p2_dep  <= r_p1_dep;
            r_p3_mode <= r_p2_mode;
            r_p3_dep  <= r_p2_dep;
            r_p4_mode <= r_p3_mode;
            r_p4_dep  <= r_p3_dep;
            r_p5_mode <= r_p4_mode;
            r_p5_dep  <= r_p4_dep;
            r_p6_mode <= r_p5_mode;
            r_p6_dep  <= r_p5_dep;
            r_dot_a   <= XW'(r_pam[0]) + XW'(r_pam[1]) + XW'(r_pam[2]);
            r_dot_b   <= XW'(r_pbm[0]) + XW'(r_pbm[1]) + XW'(r_pbm[2]);
            r_s_a     <= SW'(f_shr_tz(r_dot_a));
            r_s_b     <= SW'(f_shr_tz(r_dot_b));
            for (int i = 0; i < 3; i++) begin
                r_p1_va[i] <= w_va[i];
                r_p1_vb[i] <= w_vb[i];
                r_p1_u[i]  <= w_u1[i];
                r_pam[i]   <= PW'(w_va[i]) * PW'(w_u1[i]);
                r_pbm[i]   <= PW'(w_vb[i]) * PW'(w_u1[i]);
                r_p2_va[i] <= r_p1_va[i];
                r_p2_vb[i] <= r_p1_vb[i];
                r_p2_u[i]  <= r_p1_u[i];
                r_p3_va[i] <= r_p2_va[i];
                r_p3_vb[i] <= r_p2_vb[i];
                r_p3_u[i]  <= r_p2_u[i];
                r_qa[i]    <= XW'(r_s_a) * XW'(r_p3_u[i]);
                r_qb[i]    <= XW'(r_s_b) * XW'(r_p3_u[i]);
                r_p4_va[i] <= r_p3_va[i];
                r_p4_vb[i] <= r_p3_vb[i];
                r_pa[i]    <= SW'(f_shr_tz(r_qa[i]));
                r_pb[i]    <= SW'(f_shr_tz(r_qb[i]));
                r_p5_va[i] <= r_p4_va[i];
                r_p5_vb[i] <= r_p4_vb[i];
                r_na[i]    <= n_na[i];
                r_nb[i]    <= n_nb[i];
            end
        end
    end

    // second unit vector: direction of the new velocity of A
    logic signed [UW-1:0] w_u2 [3];

    scr_unit #(.W(W)) u_unit_vel (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_na),
        .o_u   (w_u2)
    );

    logic [SB2-1:0] w_sb2;

    scr_delay #(.WIDTH(SB2), .DEPTH(LU)) u_dly_vel (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_p6_dep, r_nb[2], r_nb[1], r_nb[0], r_na[2], r_na[1], r_na[0],
                 r_p6_mode}),
        .o_q   (w_sb2)
    );

    t_mode                r_f1_mode, r_o_mode;
    logic [6*W-1:0]       r_f1_v;
    logic signed [XW-1:0] r_fp [3];
    logic [2:0][W-1:0]    r_o_sh;
    logic [6*W-1:0]       r_o_v;
    logic [W-2:0]         w_dep2;

    assign w_dep2 = w_sb2[2 + 6*W +: W-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_mode <= t_mode'(w_sb2[1:0]);
            r_f1_v    <= w_sb2[2 +: 6*W];
            r_o_mode  <= r_f1_mode;
            r_o_v     <= r_f1_v;
            for (int i = 0; i < 3; i++) begin
                r_fp[i] <= XW'(w_u2[i]) * XW'(signed'({1'b0, w_dep2}));
                if (r_f1_mode == MODE_SPHERE) begin
                    r_o_sh[i] <= f_sat(SSW'(0) - SSW'(f_shr_tz(r_fp[i])));
                end else begin
                    r_o_sh[i] <= '0;
                end
            end
        end
    end

    assign o_m_axis_tdata = OUT_TW'({r_o_sh, r_o_v});

    // pipeline holds as a whole while the output word is stalled
    a_hold_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid chain moved during a stall");

    // only the sphere pair response moves A
    a_shift_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_o_mode != MODE_SPHERE) |-> (r_o_sh == '0))
        else $error("nonzero shift outside sphere mode");

    // no input is accepted while a word offered to the output is not taken
    a_ready_link : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while output stalled");

endmodule

`default_nettype wire

// ----- tb/collision_checker.sv -----
// ---------------------------------------------------------------------------
// collision_checker
// Watches both streams of the collision response block, computes the expected
// velocities and position shift of every accepted pair and compares them with
// the words that leave the block, in order.
// ---------------------------------------------------------------------------
module collision_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    input  wire logic         i_s_axis_tready,
    // offset x/y/z, velocity a x/y/z, velocity b x/y/z, depth, zero fill
    input  wire logic [319:0] i_s_axis_tdata,
    // mode
    input  wire logic [1:0]   i_s_axis_tuser,
    input  wire logic         i_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // new velocity a x/y/z, new velocity b x/y/z, shift a x/y/z
    input  wire logic [287:0] i_m_axis_tdata,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import scr_pkg::*;

    localparam int UB = 30;

    typedef longint t_vec3 [3];

    logic [287:0] response_q [$];
    string        field_name [9] = '{"new_velocity_a_x", "new_velocity_a_y",
        "new_velocity_a_z", "new_velocity_b_x", "new_velocity_b_y",
        "new_velocity_b_z", "shift_a_x", "shift_a_y", "shift_a_z"};

    function automatic longint unsigned magn(input longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // arithmetic shift on the magnitude, so rounding is toward zero
    function automatic longint shr_tz(input longint x, input int sh);
        longint unsigned m;
        m = magn(x) >> sh;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic void unit_dir(input t_vec3 d, output t_vec3 u);
        longint unsigned m, sum, len, q;
        longint unsigned e [3];
        int s;
        m = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++) if (magn(d[i]) > m) m = magn(d[i]);
        if (m == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return;
        end
        while ((m >> s) >= (64'd1 << 30)) s++;
        for (int i = 0; i < 3; i++) begin
            e[i] = magn(d[i]) >> s;
            sum += e[i] * e[i];
        end
        len = int_sqrt(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = (e[i] << UB) / len;
            u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void along_line(input t_vec3 v, input t_vec3 u, output t_vec3 p);
        longint dotp, s;
        dotp = v[0] * u[0] + v[1] * u[1] + v[2] * u[2];
        s = shr_tz(dotp, UB);
        for (int i = 0; i < 3; i++) p[i] = shr_tz(s * u[i], UB);
    endfunction

    function automatic logic [287:0] collide(input logic [1:0] mode, input logic [319:0] w);
        t_vec3 d, va, vb, na, nb, sh, u, pa, pb;
        longint depth;
        logic [287:0] r;
        for (int i = 0; i < 3; i++) begin
            d[i]  = longint'($signed(w[32*i +: 32]));
            va[i] = longint'($signed(w[96 + 32*i +: 32]));
            vb[i] = longint'($signed(w[192 + 32*i +: 32]));
            sh[i] = 0;
        end
        depth = longint'({33'd0, w[288 +: 31]});
        if (t_mode'(mode) == MODE_SPHERE) begin
            unit_dir(d, u);
            along_line(va, u, pa);
            along_line(vb, u, pb);
            for (int i = 0; i < 3; i++) begin
                na[i] = clamp32(va[i] + pb[i] - pa[i]);
                nb[i] = clamp32(vb[i] + pa[i] - pb[i]);
            end
            unit_dir(na, u);
            for (int i = 0; i < 3; i++) sh[i] = clamp32(-shr_tz(u[i] * depth, UB));
        end else if (t_mode'(mode) == MODE_MESH) begin
            for (int i = 0; i < 3; i++) begin
                na[i] = clamp32(-va[i]);
                nb[i] = clamp32(-vb[i]);
            end
        end else begin
            // mode 3 behaves as no response
            na = va;
            nb = vb;
        end
        for (int i = 0; i < 3; i++) begin
            r[32*i +: 32]       = na[i][31:0];
            r[96 + 32*i +: 32]  = nb[i][31:0];
            r[192 + 32*i +: 32] = sh[i][31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        logic [287:0] want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                response_q.push_back(collide(i_s_axis_tuser, i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (response_q.size() == 0) begin
                    report_mismatch("output word with no pair pending");
                end else begin
                    want = response_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (i_m_axis_tdata[32*k +: 32] !== want[32*k +: 32])
                            report_mismatch($sformatf("%s got %h expected %h",
                                field_name[k], i_m_axis_tdata[32*k +: 32],
                                want[32*k +: 32]));
                end
            end
        end
        o_pending = response_q.size();
    end
endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives collision pairs into the response block: directed corner pairs,
// then random pairs under several sender/receiver idling patterns, including
// a long receiver hold that backs up the pipeline.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 400;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [287:0] m_tdata;
    int           fail_count;
    int           pending;

    int idle_pct;
    int stall_pct;
    logic hold_req;
    logic hold_done;
    int hold_left;
    int quiet_cycles;
    int mode_count [4];

    sphere_collision_response #(.VALUE_WIDTH(32)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    collision_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stalls plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // no word moving on either side for too long means a hang
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [319:0] pack_pair(
        input logic [31:0] ox, oy, oz, ax, ay, az, bx, by, bz, input logic [30:0] dep);
        return {1'b0, dep, bz, by, bx, az, ay, ax, oz, oy, ox};
    endfunction

    function automatic logic [31:0] pick_value();
        int k;
        case ($urandom_range(7))
            0, 1, 2: return $urandom;
            3: begin
                k = $urandom_range(4);
                return k == 0 ? 32'h8000_0000 : k == 1 ? 32'h7fff_ffff :
                       k == 2 ? 32'd0 : k == 3 ? 32'd1 : 32'hffff_ffff;
            end
            default: begin
                // physically sized values: a few integer bits, random sign
                k = $urandom_range(24, 4);
                return $signed($urandom & ((32'd1 << k) - 1)) *
                       ($urandom_range(1) ? 1 : -1);
            end
        endcase
    endfunction

    task automatic send_pair(input logic [1:0] mode, input logic [319:0] w);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= mode;
        mode_count[mode]++;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [1:0] mode;
        logic [30:0] dep;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: mode = MODE_SPHERE;
                6: mode = MODE_MESH;
                7: mode = MODE_NONE;
                8: mode = 2'd3;
                default: mode = 2'($urandom);
            endcase
            dep = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(20'hfffff));
            send_pair(mode, pack_pair(pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), pick_value(), dep));
        end
    endtask

    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MONE = 32'hffff_0000;

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_NONE;
        hold_req  = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        foreach (mode_count[i]) mode_count[i] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // head-on pair along x
        send_pair(MODE_SPHERE, pack_pair(ONE, 0, 0, MONE, 0, 0, ONE, 0, 0, 31'h8000));
        // oblique pair
        send_pair(MODE_SPHERE, pack_pair(ONE, ONE, 0, 32'h3_0000, MONE, ONE,
            0, 32'h2_0000, MONE, 31'h1_0000));
        // zero offset: velocities pass through
        send_pair(MODE_SPHERE, pack_pair(0, 0, 0, ONE, MONE, ONE, MONE, ONE, 0, 31'h4000));
        // zero new velocity of a: no shift
        send_pair(MODE_SPHERE, pack_pair(ONE, 0, 0, 0, 0, 0, 0, 0, 0, 31'h7fff_ffff));
        send_pair(MODE_SPHERE, pack_pair(ONE, 0, 0, 0, ONE, 0, ONE, 0, 0, 31'h7fff_ffff));
        // extremes in every field
        send_pair(MODE_SPHERE, pack_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
            MINV, MINV, MINV, 31'h7fff_ffff));
        send_pair(MODE_SPHERE, pack_pair(MINV, MINV, MINV, MINV, MINV, MINV,
            MAXV, MAXV, MAXV, 31'h7fff_ffff));
        send_pair(MODE_SPHERE, pack_pair(MINV, MAXV, 1, MAXV, MINV, 0,
            MINV, MAXV, 1, 31'd0));
        send_pair(MODE_SPHERE, pack_pair(1, 0, 0, MAXV, MAXV, 0, MINV, MINV, 0, 31'd1));
        send_pair(MODE_SPHERE, pack_pair(32'hffff_ffff, 1, 32'hffff_ffff, 1, 1, 1,
            32'hffff_ffff, 0, 0, 31'd1));
        // mesh: negation, most negative saturates
        send_pair(MODE_MESH, pack_pair(ONE, ONE, ONE, MINV, MAXV, 0, MINV, 1, MONE, 31'h100));
        send_pair(MODE_MESH, pack_pair(0, 0, 0, ONE, MONE, 32'hffff_ffff,
            MAXV, MINV, MINV, 31'h7fff_ffff));
        send_pair(MODE_NONE, pack_pair(ONE, ONE, ONE, MINV, MAXV, 0, MAXV, MINV, 1, 31'h7fff_ffff));
        send_pair(2'd3, pack_pair(ONE, 0, 0, MONE, 0, 0, ONE, 0, 0, 31'h8000));
        send_pair(2'd3, pack_pair(MINV, MAXV, 0, MAXV, MINV, 1, 0, 0, MINV, 31'd0));
        send_pair(MODE_SPHERE, pack_pair(0, 0, MONE, 0, 0, ONE, 0, 0, MONE, 31'h10000));
        send_pair(MODE_SPHERE, pack_pair(0, 32'h10, 0, 0, 32'h7fff_0000, 0,
            0, 32'h8001_0000, 0, 31'h3fff_ffff));

        // random pairs: back-to-back with a long receiver hold at the start, then under idling
        hold_req <= 1'b1;
        send_random(500);
        idle_pct = 78;
        stall_pct = 0;
        send_random(300);
        idle_pct = 0;
        stall_pct = 78;
        send_random(350);
        idle_pct = 32;
        stall_pct = 32;
        send_random(400);
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("pairs sent: %0d sphere, %0d mesh, %0d no response, %0d mode 3",
            mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("idling patterns: none, sender 78%%, receiver 78%%, both 32%%, one long hold");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/scr_pkg.sv
hw/rtl/scr_delay.sv
hw/rtl/scr_unit.sv
hw/rtl/sphere_collision_response.sv
tb/collision_checker.sv
tb/testbench.sv
